### src/tbme_pkg.sv
// shared types and constants for the tag bitmap matrix engine
package tbme_pkg;

  localparam int RECORDS = 64;
  localparam int TAGS    = 64;
  localparam int ID_W    = 6;
  localparam int CNT_W   = 7;

  localparam logic [CNT_W-1:0] LIST_EMPTY = CNT_W'(RECORDS);

  typedef enum logic [2:0] {
    OP_TEST      = 3'd0,
    OP_SET       = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_ALLOC_REC = 3'd3,
    OP_FREE_REC  = 3'd4,
    OP_ALLOC_TAG = 3'd5,
    OP_FREE_TAG  = 3'd6,
    OP_QUERY     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REC_FULL = 2'd1,
    ST_TAG_FULL = 2'd2,
    ST_BAD_ID   = 2'd3
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  rec_id;
    logic [ID_W-1:0]  tag_id;
    logic             last;
    logic             bad;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic             bit_value;
    logic [ID_W-1:0]  index;
    logic             found;
    logic             end_of_run;
  } res_t;

endpackage

### src/tbme_front.sv
// front end: accepts input beats, checks id ranges and queues decoded commands
module tbme_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             q_valid,
  output tbme_pkg::cmd_t   q_entry,
  input  logic             q_pop
);

  tbme_pkg::cmd_t cmd_in;
  tbme_pkg::cmd_t ent [2];
  logic           wp;
  logic           rp;
  logic [1:0]     count;
  logic           rec_ok;
  logic           tag_ok;
  logic           push;
  logic           pop;

  always_comb begin
    cmd_in.op     = tbme_pkg::op_t'(s_axis_tdata[2:0]);
    cmd_in.rec_id = s_axis_tdata[8:3];
    cmd_in.tag_id = s_axis_tdata[14:9];
    cmd_in.last   = s_axis_tlast;
    rec_ok = {1'b0, cmd_in.rec_id} < tbme_pkg::CNT_W'(tbme_pkg::RECORDS);
    tag_ok = {1'b0, cmd_in.tag_id} < tbme_pkg::CNT_W'(tbme_pkg::TAGS);
    unique case (cmd_in.op)
      tbme_pkg::OP_TEST,
      tbme_pkg::OP_SET,
      tbme_pkg::OP_CLEAR:    cmd_in.bad = !rec_ok || !tag_ok;
      tbme_pkg::OP_FREE_REC: cmd_in.bad = !rec_ok;
      tbme_pkg::OP_FREE_TAG,
      tbme_pkg::OP_QUERY:    cmd_in.bad = !tag_ok;
      default:               cmd_in.bad = 1'b0;
    endcase
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign pop           = q_pop && q_valid;
  assign q_entry       = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### src/tbme_back.sv
// back end: runs commands against the bit matrix and free lists, drives results
module tbme_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tbme_pkg::cmd_t   q_entry,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output tbme_pkg::res_t   res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SCAN_END,
    S_SWEEP
  } state_t;

  localparam int IW = tbme_pkg::ID_W;
  localparam int CW = tbme_pkg::CNT_W;
  localparam int TW = tbme_pkg::TAGS;

  state_t          state;
  tbme_pkg::cmd_t  cur;

  logic [TW-1:0]   rows [tbme_pkg::RECORDS];
  logic            row_valid [tbme_pkg::RECORDS];
  logic [CW-1:0]   links [tbme_pkg::RECORDS];
  logic [IW-1:0]   stack [tbme_pkg::TAGS];

  logic [TW-1:0]   rd_data;
  logic            rd_valid;
  logic [CW-1:0]   link_rd;
  logic [IW-1:0]   stk_rd;

  logic [CW-1:0]   free_head;
  logic [CW-1:0]   rec_used;
  logic [CW-1:0]   tags_used;
  logic [CW-1:0]   stk_cnt;
  logic [TW-1:0]   mask;
  logic [CW-1:0]   cnt;
  logic [IW-1:0]   pend;
  logic            pend_v;

  logic [IW-1:0]   rd_addr;
  logic [TW-1:0]   row;
  logic [TW-1:0]   cur_bit;
  logic [TW-1:0]   in_bit;
  logic            can_emit;
  logic            in_range;
  logic            match;
  logic            adv;
  logic [CW-1:0]   stk_top;

  assign row      = rd_valid ? rd_data : '0;
  assign cur_bit  = TW'(1) << cur.tag_id;
  assign in_bit   = TW'(1) << q_entry.tag_id;
  assign can_emit = !res_valid || res_ready;
  assign in_range = cnt < rec_used;
  assign match    = (row & mask) == mask;
  assign adv      = (state == S_SCAN) && in_range && !(match && pend_v && !can_emit);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign stk_top  = stk_cnt - CW'(1);

  always_comb begin
    unique case (state)
      S_IDLE: begin
        if (q_entry.op == tbme_pkg::OP_FREE_TAG || q_entry.op == tbme_pkg::OP_QUERY) begin
          rd_addr = '0;
        end else begin
          rd_addr = q_entry.rec_id;
        end
      end
      S_EXEC:  rd_addr = cur.rec_id;
      S_SCAN:  rd_addr = adv ? IW'(cnt + CW'(1)) : cnt[IW-1:0];
      S_SWEEP: rd_addr = in_range ? IW'(cnt + CW'(1)) : cnt[IW-1:0];
      default: rd_addr = cnt[IW-1:0];
    endcase
  end

  // registered reads of all three stores
  always_ff @(posedge clk) begin
    rd_data  <= rows[rd_addr];
    rd_valid <= row_valid[rd_addr];
    link_rd  <= links[free_head[IW-1:0]];
    stk_rd   <= stack[stk_top[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      free_head <= tbme_pkg::LIST_EMPTY;
      rec_used  <= '0;
      tags_used <= '0;
      stk_cnt   <= '0;
      mask      <= '0;
      cnt       <= '0;
      pend_v    <= 1'b0;
      for (int i = 0; i < tbme_pkg::RECORDS; i++) begin
        row_valid[i] <= 1'b0;
      end
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_entry;
            state <= S_EXEC;
            if (q_entry.op == tbme_pkg::OP_FREE_TAG && !q_entry.bad) begin
              if (stk_cnt < CW'(tbme_pkg::TAGS)) begin
                stack[stk_cnt[IW-1:0]] <= q_entry.tag_id;
                stk_cnt <= stk_cnt + CW'(1);
              end
              cnt   <= '0;
              state <= S_SWEEP;
            end else if (q_entry.op == tbme_pkg::OP_QUERY && !q_entry.bad) begin
              mask <= mask | in_bit;
              if (q_entry.last) begin
                cnt    <= '0;
                pend_v <= 1'b0;
                state  <= S_SCAN;
              end
            end
          end
        end
        S_EXEC: begin
          if (can_emit) begin
            res_valid <= 1'b1;
            res       <= '{status: tbme_pkg::ST_OK, bit_value: 1'b0, index: '0,
                           found: 1'b0, end_of_run: 1'b1};
            state     <= S_IDLE;
            if (cur.bad) begin
              res.status <= tbme_pkg::ST_BAD_ID;
              if (cur.op == tbme_pkg::OP_QUERY && cur.last) mask <= '0;
            end else begin
              unique case (cur.op)
                tbme_pkg::OP_TEST: res.bit_value <= row[cur.tag_id];
                tbme_pkg::OP_SET: begin
                  rows[cur.rec_id]      <= row | cur_bit;
                  row_valid[cur.rec_id] <= 1'b1;
                end
                tbme_pkg::OP_CLEAR: begin
                  rows[cur.rec_id]      <= row & ~cur_bit;
                  row_valid[cur.rec_id] <= 1'b1;
                end
                tbme_pkg::OP_ALLOC_REC: begin
                  if (free_head < tbme_pkg::LIST_EMPTY) begin
                    free_head                     <= link_rd;
                    row_valid[free_head[IW-1:0]]  <= 1'b0;
                    res.index                     <= free_head[IW-1:0];
                  end else if (rec_used >= CW'(tbme_pkg::RECORDS)) begin
                    res.status <= tbme_pkg::ST_REC_FULL;
                  end else begin
                    rec_used                     <= rec_used + CW'(1);
                    row_valid[rec_used[IW-1:0]]  <= 1'b0;
                    res.index                    <= rec_used[IW-1:0];
                  end
                end
                tbme_pkg::OP_FREE_REC: begin
                  row_valid[cur.rec_id] <= 1'b0;
                  links[cur.rec_id]     <= free_head;
                  free_head             <= {1'b0, cur.rec_id};
                end
                tbme_pkg::OP_ALLOC_TAG: begin
                  if (stk_cnt != '0) begin
                    stk_cnt   <= stk_top;
                    res.index <= stk_rd;
                  end else if (tags_used >= CW'(tbme_pkg::TAGS)) begin
                    res.status <= tbme_pkg::ST_TAG_FULL;
                  end else begin
                    tags_used <= tags_used + CW'(1);
                    res.index <= tags_used[IW-1:0];
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (!in_range) begin
            state <= S_SCAN_END;
          end else if (adv) begin
            if (match) begin
              if (pend_v) begin
                res_valid <= 1'b1;
                res       <= '{status: tbme_pkg::ST_OK, bit_value: 1'b0, index: pend,
                               found: 1'b1, end_of_run: 1'b0};
              end
              pend   <= cnt[IW-1:0];
              pend_v <= 1'b1;
            end
            cnt <= cnt + CW'(1);
          end
        end
        S_SCAN_END: begin
          if (can_emit) begin
            res_valid <= 1'b1;
            res       <= '{status: tbme_pkg::ST_OK, bit_value: 1'b0,
                           index: pend_v ? pend : '0, found: pend_v, end_of_run: 1'b1};
            mask      <= '0;
            pend_v    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (in_range) begin
            rows[cnt[IW-1:0]]      <= row & ~cur_bit;
            row_valid[cnt[IW-1:0]] <= 1'b1;
            cnt                    <= cnt + CW'(1);
          end else if (can_emit) begin
            res_valid <= 1'b1;
            res       <= '{status: tbme_pkg::ST_OK, bit_value: 1'b0, index: '0,
                           found: 1'b0, end_of_run: 1'b1};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/tag_bitmap_matrix_engine.sv
// top level of the tag bitmap matrix engine: 64 x 64 bit matrix of records
// by tags, a linked free list for record ids and a stack for recycled tag ids
// input channel s_axis: one beat is one operation; tdata carries func and the
// record and tag ids, tlast marks the final term of a query
// output channel m_axis: one or more beats per operation; tlast marks the last
// result beat of that operation
// a two-entry command queue sits between the decode front and the execution
// back, so input beats keep flowing while the back works or waits on m_axis
// single-row operations hold the back end for a take step and an execute step,
// and it takes no new operation until their result beat is issued
// free tag walks the used rows one per cycle, then issues its result beat; a
// final query term scans the used rows likewise, pausing on a stalled receiver,
// then issues a last beat; matches stream out in row order
// a stalled receiver holds the back end: the result register keeps its beat
// and the scan pauses on the current row; the queue then fills and drops
// s_axis_tready
// reset clears all control state and marks every row invalid (reads as zero);
// no clearing pass is needed, the block takes beats right after reset
module tag_bitmap_matrix_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // func[2:0], rec_id[8:3], tag_id[14:9]
  input  logic        s_axis_tlast,   // last query term
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status[1:0], bit_value[2], index[8:3], found[9]
  output logic        m_axis_tlast    // end of run
);

  logic            q_valid;
  logic            q_pop;
  tbme_pkg::cmd_t  q_entry;
  tbme_pkg::res_t  res;

  tbme_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop)
  );

  tbme_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {6'b0, res.found, res.index, res.bit_value, res.status};
  assign m_axis_tlast = res.end_of_run;

`ifndef NO_ASSERTIONS
  // a matching row is only ever reported with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[1:0] == tbme_pkg::ST_OK)
    else $error("found result with non-ok status");

  // input back-pressure only when the command queue holds work
  a_ready_queue: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");

  // the back end pops only a queue that holds a command
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
